// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define SKA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define SKA_ASSERT(label, prop, msg) \
  `SKA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/ska_pkg.sv =====
// types, constants and defaults for the scalar kalman adc smoother
`timescale 1ns / 1ps

package ska_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned THR_W     = 12;
  localparam int unsigned BLEND_W   = 16;
  localparam int unsigned R_SHIFT   = 16;
  localparam int unsigned DIV_Q_W   = 32;
  localparam int unsigned DIV_D_W   = MUL_W + R_SHIFT + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W + 1);

  localparam logic [MUL_W-1:0]   PROC_NOISE_RST = 32'd429497;
  localparam logic [MUL_W-1:0]   MEAS_NOISE_RST = 32'd327680;
  localparam logic [THR_W-1:0]   JUMP_THR_RST   = 12'd10;
  localparam logic [BLEND_W-1:0] BLEND_W_RST    = 16'd25035;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_NOISE = 3'd0,
    CFG_MEAS_NOISE = 3'd1,
    CFG_JUMP_THR   = 3'd2,
    CFG_BLEND_W    = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_BLEND,
    S_PRIOR,
    S_DIV,
    S_MAG,
    S_COV,
    S_UPD
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

// ===== sv/ska_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
`timescale 1ns / 1ps

module ska_mul (
  input  logic                       clk_i,
  input  logic [ska_pkg::MUL_W-1:0]  a_i,
  input  logic [ska_pkg::MUL_W-1:0]  b_i,
  output logic [ska_pkg::PROD_W-1:0] prod_o
);
  import ska_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/ska_div.sv =====
// restoring divider, one quotient bit per cycle, for the kalman gain
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ska_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ska_pkg::MUL_W-1:0]   dividend_i,
  input  logic [ska_pkg::DIV_D_W-1:0] divisor_i,
  output ska_pkg::div_ctrl_t          stat_o,
  output logic [ska_pkg::DIV_Q_W-1:0] quot_o
);
  import ska_pkg::*;

  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_Q_W-1:0]   quot_q, quot_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, 1'b0};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = DIV_D_W'(dividend_i);
      quot_d = '0;
      cnt_d  = DIV_CNT_W'(DIV_Q_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      quot_d = {quot_q[DIV_Q_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign stat_o.start = start_i;
  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quot_o       = quot_q;

  `SKA_ASSERT(a_start_idle, start_i |-> !busy_q, "divider started while busy")
  `SKA_ASSERT(a_start_busy, start_i |=> busy_q && !done_q, "divider did not start")
  `SKA_ASSERT(a_done_clear, done_q |-> !busy_q && cnt_q == '0, "divider done while counting")

endmodule

// ===== sv/scalar_kalman_adc_smoother.sv =====
// top level of the scalar kalman adc smoother: sequencer, state and config registers
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One-dimensional Kalman smoother for raw ADC samples in fixed point. Each sample
// gives one saturated Q12.8 estimate, and the next sample is accepted only once the
// last one has reached the output register. The restoring divider forms the gain,
// one quotient bit per cycle, and hands it over to the sequencer. The other sequencer
// steps run around one shared 32x32 multiplier that is used in turn for the jump
// blend, the correction and the covariance update.
// in_ready_o is high only while the sequencer is idle; a finished result waits in
// the output register and the next sample may be accepted meanwhile. Configuration
// writes take effect at once and are meant for idle periods.
module scalar_kalman_adc_smoother #(
  parameter int unsigned SAMPLE_BITS = ska_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = ska_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ska_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ska_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] estimate_o
);
  import ska_pkg::*;

  localparam int unsigned EST_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned CMP_W   = 48;
  localparam int unsigned SUM_W   = MUL_W + 2;
  localparam int unsigned MAG_W   = MUL_W + 1;
  localparam logic [EST_W-1:0]  EST_MAX   = {EST_W{1'b1}};
  localparam logic [PROD_W:0]   HALF_BL   = (PROD_W + 1)'(32768);
  localparam logic [PROD_W:0]   HALF_BL_L = (PROD_W + 1)'(32767);
  localparam logic [PROD_W:0]   HALF_MAG  = (PROD_W + 1)'(64'h8000_0000);

  // configuration registers
  logic [MUL_W-1:0]   proc_noise_q;
  logic [MUL_W-1:0]   meas_noise_q;
  logic [THR_W-1:0]   jump_thr_q;
  logic [BLEND_W-1:0] blend_w_q;

  // filter state
  logic [EST_W-1:0] est_reg_q, est_reg_d;
  logic [MUL_W-1:0] cov_reg_q, cov_reg_d;

  // per-item work registers
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [EST_W-1:0]       diff_q, diff_d;
  logic                   up_q, up_d;
  logic                   jump_q, jump_d;
  logic [MUL_W-1:0]       ppred_q, ppred_d;
  logic [EST_W-1:0]       prior_q, prior_d;
  logic [MUL_W-1:0]       gain_q, gain_d;
  logic [EST_W-1:0]       est_new_q, est_new_d;

  logic             out_valid_q, out_valid_d;
  logic [EST_W-1:0] out_est_q;

  state_e state_q, state_d;

  // sequencer outputs
  logic in_ready;
  logic ld_prep;
  logic ld_prior;
  logic ld_gain;
  logic ld_est;
  logic out_load;
  logic in_accept;

  // shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [DIV_D_W-1:0] denom;
  logic [DIV_Q_W-1:0] quot;
  div_ctrl_t          div_stat;
  logic               div_start;

  logic [EST_W-1:0]   sfx;
  logic [MUL_W:0]     ppred_sum;
  logic [PROD_W:0]    blend_sum;
  logic [EST_W-1:0]   blend_step;
  logic [PROD_W:0]    mag_sum;
  logic [MAG_W-1:0]   mag;
  logic [SUM_W-1:0]   up_sum;
  logic [MUL_W-1:0]   cov_new;

  assign in_accept = in_valid_i && in_ready;
  assign out_load  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) begin
        state_d = S_PREP;
      end
      S_PREP:  state_d = S_BLEND;
      S_BLEND: state_d = S_PRIOR;
      S_PRIOR: state_d = S_DIV;
      S_DIV:   if (div_stat.done) begin
        state_d = S_MAG;
      end
      S_MAG:   state_d = S_COV;
      S_COV:   state_d = S_UPD;
      S_UPD:   if (out_load) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ld_prep   = 1'b0;
    div_start = 1'b0;
    ld_prior  = 1'b0;
    ld_gain   = 1'b0;
    ld_est    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_PREP:  ld_prep = 1'b1;
      S_BLEND: begin
        div_start = 1'b1;
        mul_a     = MUL_W'(diff_q);
        mul_b     = MUL_W'(blend_w_q);
      end
      S_PRIOR: ld_prior = 1'b1;
      S_DIV:   ld_gain = div_stat.done;
      S_MAG: begin
        mul_a = gain_q;
        mul_b = MUL_W'(diff_q);
      end
      S_COV, S_UPD: begin
        ld_est = (state_q == S_COV);
        mul_a  = MUL_W'(0) - gain_q;
        mul_b  = ppred_q;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // jump test and predicted covariance
  always_comb begin
    sfx       = {sample_q, {FRAC_BITS{1'b0}}};
    up_d      = sfx >= est_reg_q;
    diff_d    = up_d ? (sfx - est_reg_q) : (est_reg_q - sfx);
    jump_d    = CMP_W'(diff_d) >= CMP_W'({jump_thr_q, {FRAC_BITS{1'b0}}});
    ppred_sum = {1'b0, cov_reg_q} + {1'b0, proc_noise_q};
    ppred_d   = ppred_sum[MUL_W] ? {MUL_W{1'b1}} : ppred_sum[MUL_W-1:0];
  end

  // blend rounded half up, as a step from the old estimate
  always_comb begin
    blend_sum  = {1'b0, prod} + (up_q ? HALF_BL : HALF_BL_L);
    blend_step = blend_sum[BLEND_W +: EST_W];
    if (!jump_q) begin
      prior_d = est_reg_q;
    end else if (up_q) begin
      prior_d = est_reg_q + blend_step;
    end else begin
      prior_d = est_reg_q - blend_step;
    end
  end

  // gain with the zero measurement noise cases
  always_comb begin
    if (meas_noise_q == '0) begin
      gain_d = (ppred_q == '0) ? '0 : {MUL_W{1'b1}};
    end else begin
      gain_d = quot;
    end
  end

  // correction and saturation
  always_comb begin
    mag_sum = {1'b0, prod} + HALF_MAG;
    mag     = mag_sum[PROD_W:MUL_W];
    up_sum  = SUM_W'(prior_q) + SUM_W'(mag);
    if (up_q) begin
      est_new_d = (up_sum > SUM_W'(EST_MAX)) ? EST_MAX : up_sum[EST_W-1:0];
    end else if (mag > MAG_W'(prior_q)) begin
      est_new_d = '0;
    end else begin
      est_new_d = prior_q - mag[EST_W-1:0];
    end
  end

  always_comb begin
    cov_new     = (gain_q == '0) ? ppred_q : prod[PROD_W-1:MUL_W];
    est_reg_d   = est_reg_q;
    cov_reg_d   = cov_reg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == S_UPD && out_load) begin
      est_reg_d   = est_new_q;
      cov_reg_d   = cov_new;
      out_valid_d = 1'b1;
    end
  end

  assign denom = DIV_D_W'({meas_noise_q, {R_SHIFT{1'b0}}}) + DIV_D_W'(ppred_q);

  ska_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ska_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ppred_q),
    .divisor_i  (denom),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      est_reg_q    <= '0;
      cov_reg_q    <= '0;
      proc_noise_q <= PROC_NOISE_RST;
      meas_noise_q <= MEAS_NOISE_RST;
      jump_thr_q   <= JUMP_THR_RST;
      blend_w_q    <= BLEND_W_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      est_reg_q   <= est_reg_d;
      cov_reg_q   <= cov_reg_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_PROC_NOISE: proc_noise_q <= cfg_data_i[MUL_W-1:0];
          CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i[MUL_W-1:0];
          CFG_JUMP_THR:   jump_thr_q   <= cfg_data_i[THR_W-1:0];
          CFG_BLEND_W:    blend_w_q    <= cfg_data_i[BLEND_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (ld_prep) begin
      diff_q  <= diff_d;
      up_q    <= up_d;
      jump_q  <= jump_d;
      ppred_q <= ppred_d;
    end
    if (ld_prior) begin
      prior_q <= prior_d;
    end
    if (ld_gain) begin
      gain_q <= gain_d;
    end
    if (ld_est) begin
      est_new_q <= est_new_d;
    end
    if (state_q == S_UPD && out_load) begin
      out_est_q <= est_new_q;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;

  `SKA_ASSERT(a_accept_prep, in_accept |=> state_q == S_PREP, "item accepted but not started")
  `SKA_ASSERT(a_done_in_div, div_stat.done |-> state_q == S_DIV, "gain ready outside divide step")
  `SKA_ASSERT(a_start_blend, div_stat.start |-> state_q == S_BLEND && !div_stat.busy,
              "divider started out of sequence")
  `SKA_ASSERT(a_upd_result, state_q == S_UPD && out_load |=> out_valid_q && state_q == S_IDLE,
              "finished item not presented")

endmodule
